// ===== design/lpc_pkg.sv =====
// shared types and constants of the length-prefixed command parser
`default_nettype none
package lpc_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHR_E     = 8'h65;
  localparam logic [7:0] CHR_O     = 8'h6f;
  localparam logic [7:0] CHR_L     = 8'h6c;
  localparam logic [7:0] CHR_COLON = 8'h3a;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [3:0] RADIX     = 4'd10;

  localparam logic [2:0] KIND_FRAMING = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD = 3'd1;
  localparam logic [2:0] KIND_EMPTY   = 3'd2;
  localparam logic [2:0] KIND_OPT_END = 3'd3;
  localparam logic [2:0] KIND_CMD_END = 3'd4;
  localparam logic [2:0] KIND_IN_END  = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  localparam logic [1:0] ROLE_KEY   = 2'd0;
  localparam logic [1:0] ROLE_VALUE = 2'd1;
  localparam logic [1:0] ROLE_WORD  = 2'd2;

  localparam logic [2:0] ERR_BAD_TOKEN = 3'd0;
  localparam logic [2:0] ERR_NO_COLON  = 3'd1;
  localparam logic [2:0] ERR_EARLY_END = 3'd2;
  localparam logic [2:0] ERR_EMPTY_CMD = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_SPACE,
    CLS_DIGIT,
    CLS_COLON,
    CLS_E,
    CLS_O,
    CLS_L,
    CLS_OTHER
  } cls_t;

  typedef enum logic [2:0] {
    MODE_BETWEEN,
    MODE_LEN_START,
    MODE_LEN_DIGITS,
    MODE_PAYLOAD,
    MODE_ERROR
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       at_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [1:0] role;
    logic       first_of_string;
    logic       last_of_string;
    logic [7:0] word_index;
    logic       unpaired_key;
    logic [2:0] error_code;
  } out_item_t;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic       valid;
    cls_t       cls;
    logic [7:0] data;
  } cls_item_t;

endpackage
`default_nettype wire

// ===== design/lpc_front.sv =====
// front end: classifies incoming bytes and queues them for the back end
`default_nettype none
module lpc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire lpc_pkg::in_item_t  in_item,
  output lpc_pkg::cls_item_t      head,
  input  wire logic               take
);

  localparam int AW = lpc_pkg::QUEUE_AW;

  lpc_pkg::cls_item_t      slots [lpc_pkg::QUEUE_DEPTH];
  logic [AW-1:0]           wr_ptr;
  logic [AW-1:0]           rd_ptr;
  logic [AW:0]             count;
  lpc_pkg::cls_t           cls;
  logic                    wr_en;
  logic                    rd_en;

  always_comb begin
    if (in_item.at_end) begin
      cls = lpc_pkg::CLS_END;
    end else if (in_item.in_byte >= lpc_pkg::CHR_ZERO && in_item.in_byte <= lpc_pkg::CHR_NINE) begin
      cls = lpc_pkg::CLS_DIGIT;
    end else if (in_item.in_byte == lpc_pkg::CHR_SPACE || in_item.in_byte == lpc_pkg::CHR_CR ||
                 in_item.in_byte == lpc_pkg::CHR_LF || in_item.in_byte == lpc_pkg::CHR_TAB) begin
      cls = lpc_pkg::CLS_SPACE;
    end else if (in_item.in_byte == lpc_pkg::CHR_COLON) begin
      cls = lpc_pkg::CLS_COLON;
    end else if (in_item.in_byte == lpc_pkg::CHR_E) begin
      cls = lpc_pkg::CLS_E;
    end else if (in_item.in_byte == lpc_pkg::CHR_O) begin
      cls = lpc_pkg::CLS_O;
    end else if (in_item.in_byte == lpc_pkg::CHR_L) begin
      cls = lpc_pkg::CLS_L;
    end else begin
      cls = lpc_pkg::CLS_OTHER;
    end
  end

  assign full  = (count == (AW+1)'(lpc_pkg::QUEUE_DEPTH));
  assign wr_en = push && !full;
  assign rd_en = take && (count != '0);

  always_comb begin
    head       = slots[rd_ptr];
    head.valid = (count != '0);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= '{valid: 1'b1, cls: cls, data: in_item.in_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/lpc_back.sv =====
// back end: parser state machine and result register
`default_nettype none
module lpc_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lpc_pkg::cls_item_t  head,
  output logic                     take,
  output logic                     empty,
  input  wire logic                pop,
  output lpc_pkg::out_item_t       result
);

  localparam int LB = lpc_pkg::LENGTH_BITS;

  lpc_pkg::mode_t      mode, mode_next;
  logic                in_options, in_options_next;
  logic                options_seen, options_seen_next;
  logic [LB-1:0]       rem, rem_next;
  logic                string_started, string_started_next;
  logic [7:0]          string_count, string_count_next;
  logic [2:0]          err_code, err_code_next;
  logic                value_next, value_next_next;

  logic                out_valid;
  lpc_pkg::out_item_t  res;

  logic [LB+3:0]       rem_x10;
  logic                overflow;
  logic [LB-1:0]       rem_dec;
  logic                last;
  logic [1:0]          cur_role;
  logic [7:0]          count_inc;

  assign take  = head.valid && (!out_valid || pop);
  assign empty = !out_valid;

  // length accumulate: rem*10 + digit, overflow when upper bits set
  assign rem_x10  = ({4'b0, rem} << 3) + ({4'b0, rem} << 1) + (LB+4)'(head.data[3:0]);
  assign overflow = (rem_x10[LB+3:LB] != 4'b0);
  assign rem_dec  = (rem != '0) ? rem - 1'b1 : rem;
  assign last     = (rem_dec == '0);
  assign cur_role = in_options ? {1'b0, value_next} : lpc_pkg::ROLE_WORD;
  assign count_inc = (string_count != 8'hff) ? string_count + 1'b1 : string_count;

  // next state
  always_comb begin
    mode_next           = mode;
    in_options_next     = in_options;
    options_seen_next   = options_seen;
    rem_next            = rem;
    string_started_next = string_started;
    string_count_next   = string_count;
    err_code_next       = err_code;
    value_next_next     = value_next;
    unique case (mode)
      lpc_pkg::MODE_BETWEEN: begin
        if (head.cls == lpc_pkg::CLS_END) begin
          if (options_seen) begin
            mode_next     = lpc_pkg::MODE_ERROR;
            err_code_next = lpc_pkg::ERR_EARLY_END;
          end
        end else if (head.cls == lpc_pkg::CLS_SPACE) begin
          mode_next = mode;
        end else if (head.cls == lpc_pkg::CLS_L ||
                     (head.cls == lpc_pkg::CLS_O && !options_seen)) begin
          in_options_next     = (head.cls == lpc_pkg::CLS_O);
          string_count_next   = '0;
          string_started_next = 1'b0;
          value_next_next     = 1'b0;
          rem_next            = '0;
          mode_next           = lpc_pkg::MODE_LEN_START;
        end else begin
          mode_next     = lpc_pkg::MODE_ERROR;
          err_code_next = lpc_pkg::ERR_BAD_TOKEN;
        end
      end
      lpc_pkg::MODE_LEN_START: begin
        case (head.cls)
          lpc_pkg::CLS_END: begin
            mode_next     = lpc_pkg::MODE_ERROR;
            err_code_next = lpc_pkg::ERR_EARLY_END;
          end
          lpc_pkg::CLS_E: begin
            if (in_options) begin
              options_seen_next = 1'b1;
              in_options_next   = 1'b0;
              value_next_next   = 1'b0;
              mode_next         = lpc_pkg::MODE_BETWEEN;
            end else if (string_count == '0) begin
              mode_next     = lpc_pkg::MODE_ERROR;
              err_code_next = lpc_pkg::ERR_EMPTY_CMD;
            end else begin
              options_seen_next = 1'b0;
              mode_next         = lpc_pkg::MODE_BETWEEN;
            end
          end
          lpc_pkg::CLS_COLON: begin
            string_count_next   = count_inc;
            string_started_next = 1'b0;
            value_next_next     = value_next ^ in_options;
            rem_next            = '0;
            mode_next           = lpc_pkg::MODE_LEN_START;
          end
          lpc_pkg::CLS_DIGIT: begin
            rem_next  = LB'(head.data[3:0]);
            mode_next = lpc_pkg::MODE_LEN_DIGITS;
          end
          default: begin
            mode_next     = lpc_pkg::MODE_ERROR;
            err_code_next = lpc_pkg::ERR_NO_COLON;
          end
        endcase
      end
      lpc_pkg::MODE_LEN_DIGITS: begin
        case (head.cls)
          lpc_pkg::CLS_END: begin
            mode_next     = lpc_pkg::MODE_ERROR;
            err_code_next = lpc_pkg::ERR_EARLY_END;
          end
          lpc_pkg::CLS_DIGIT: begin
            if (overflow) begin
              mode_next     = lpc_pkg::MODE_ERROR;
              err_code_next = lpc_pkg::ERR_OVERFLOW;
            end else begin
              rem_next = rem_x10[LB-1:0];
            end
          end
          lpc_pkg::CLS_COLON: begin
            string_started_next = 1'b0;
            if (rem == '0) begin
              string_count_next = count_inc;
              value_next_next   = value_next ^ in_options;
              mode_next         = lpc_pkg::MODE_LEN_START;
            end else begin
              mode_next = lpc_pkg::MODE_PAYLOAD;
            end
          end
          default: begin
            mode_next     = lpc_pkg::MODE_ERROR;
            err_code_next = lpc_pkg::ERR_NO_COLON;
          end
        endcase
      end
      lpc_pkg::MODE_PAYLOAD: begin
        if (head.cls == lpc_pkg::CLS_END) begin
          mode_next     = lpc_pkg::MODE_ERROR;
          err_code_next = lpc_pkg::ERR_EARLY_END;
        end else if (last) begin
          string_count_next   = count_inc;
          string_started_next = 1'b0;
          value_next_next     = value_next ^ in_options;
          rem_next            = '0;
          mode_next           = lpc_pkg::MODE_LEN_START;
        end else begin
          string_started_next = 1'b1;
          rem_next            = rem_dec;
        end
      end
      lpc_pkg::MODE_ERROR: begin
        mode_next = mode;
      end
      default: begin
        mode_next = lpc_pkg::MODE_ERROR;
      end
    endcase
  end

  // result for the byte at the head
  always_comb begin
    res = '0;
    unique case (mode)
      lpc_pkg::MODE_BETWEEN: begin
        if (head.cls == lpc_pkg::CLS_END) begin
          if (options_seen) begin
            res.kind       = lpc_pkg::KIND_ERROR;
            res.error_code = lpc_pkg::ERR_EARLY_END;
          end else begin
            res.kind = lpc_pkg::KIND_IN_END;
          end
        end else if (head.cls == lpc_pkg::CLS_SPACE || head.cls == lpc_pkg::CLS_L ||
                     (head.cls == lpc_pkg::CLS_O && !options_seen)) begin
          res.kind = lpc_pkg::KIND_FRAMING;
        end else begin
          res.kind       = lpc_pkg::KIND_ERROR;
          res.error_code = lpc_pkg::ERR_BAD_TOKEN;
        end
      end
      lpc_pkg::MODE_LEN_START: begin
        case (head.cls)
          lpc_pkg::CLS_END: begin
            res.kind       = lpc_pkg::KIND_ERROR;
            res.error_code = lpc_pkg::ERR_EARLY_END;
          end
          lpc_pkg::CLS_E: begin
            if (in_options) begin
              res.kind         = lpc_pkg::KIND_OPT_END;
              res.unpaired_key = value_next;
            end else if (string_count == '0) begin
              res.kind       = lpc_pkg::KIND_ERROR;
              res.error_code = lpc_pkg::ERR_EMPTY_CMD;
            end else begin
              res.kind = lpc_pkg::KIND_CMD_END;
            end
          end
          lpc_pkg::CLS_COLON: begin
            res.kind       = lpc_pkg::KIND_EMPTY;
            res.role       = cur_role;
            res.word_index = string_count;
          end
          lpc_pkg::CLS_DIGIT: begin
            res.kind = lpc_pkg::KIND_FRAMING;
          end
          default: begin
            res.kind       = lpc_pkg::KIND_ERROR;
            res.error_code = lpc_pkg::ERR_NO_COLON;
          end
        endcase
      end
      lpc_pkg::MODE_LEN_DIGITS: begin
        case (head.cls)
          lpc_pkg::CLS_END: begin
            res.kind       = lpc_pkg::KIND_ERROR;
            res.error_code = lpc_pkg::ERR_EARLY_END;
          end
          lpc_pkg::CLS_DIGIT: begin
            if (overflow) begin
              res.kind       = lpc_pkg::KIND_ERROR;
              res.error_code = lpc_pkg::ERR_OVERFLOW;
            end else begin
              res.kind = lpc_pkg::KIND_FRAMING;
            end
          end
          lpc_pkg::CLS_COLON: begin
            if (rem == '0) begin
              res.kind       = lpc_pkg::KIND_EMPTY;
              res.role       = cur_role;
              res.word_index = string_count;
            end else begin
              res.kind = lpc_pkg::KIND_FRAMING;
            end
          end
          default: begin
            res.kind       = lpc_pkg::KIND_ERROR;
            res.error_code = lpc_pkg::ERR_NO_COLON;
          end
        endcase
      end
      lpc_pkg::MODE_PAYLOAD: begin
        if (head.cls == lpc_pkg::CLS_END) begin
          res.kind       = lpc_pkg::KIND_ERROR;
          res.error_code = lpc_pkg::ERR_EARLY_END;
        end else begin
          res.kind            = lpc_pkg::KIND_PAYLOAD;
          res.data_byte       = head.data;
          res.role            = cur_role;
          res.first_of_string = !string_started;
          res.last_of_string  = last;
          res.word_index      = string_count;
        end
      end
      lpc_pkg::MODE_ERROR: begin
        res.kind       = lpc_pkg::KIND_ERROR;
        res.error_code = err_code;
      end
      default: begin
        res.kind       = lpc_pkg::KIND_ERROR;
        res.error_code = err_code;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= lpc_pkg::MODE_BETWEEN;
      in_options     <= 1'b0;
      options_seen   <= 1'b0;
      rem            <= '0;
      string_started <= 1'b0;
      string_count   <= '0;
      err_code       <= lpc_pkg::ERR_BAD_TOKEN;
      value_next     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        mode           <= mode_next;
        in_options     <= in_options_next;
        options_seen   <= options_seen_next;
        rem            <= rem_next;
        string_started <= string_started_next;
        string_count   <= string_count_next;
        err_code       <= err_code_next;
        value_next     <= value_next_next;
        out_valid      <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res;
    end
  end

endmodule
`default_nettype wire

// ===== design/length_prefixed_command_parser_core.sv =====
// top level of the length-prefixed command parser
`default_nettype none
// Parses a byte stream of optional 'o'...'e' option lists and 'l'...'e' command
// lists of length-prefixed strings, one result per input byte (or end mark).
// Bytes are classified on entry and wait in a four-entry queue; the parser
// state machine takes one byte per cycle whenever its result register is free
// or being popped, so with pop held high the block sustains one item per clock
// and each result is written to the result register when its byte leaves the
// queue. The length digits are accumulated with a single multiply-by-ten adder
// per byte. After the first error every further byte answers with the same
// error until reset.
module length_prefixed_command_parser_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire lpc_pkg::in_item_t  in_item,
  output logic                    empty,
  input  wire logic               pop,
  output lpc_pkg::out_item_t      result
);

  lpc_pkg::cls_item_t head;
  logic               take;

  lpc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .head    (head),
    .take    (take)
  );

  lpc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .take   (take),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

`ifndef SYNTHESIS
  // once an error has been handed out, every later result is an error too
  a_sticky_error: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && result.kind == lpc_pkg::KIND_ERROR)
      |=> (empty || result.kind == lpc_pkg::KIND_ERROR))
    else $error("result after an error is not an error");

  // string marks and data only on payload results
  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind != lpc_pkg::KIND_PAYLOAD)
      |-> (result.data_byte == 8'd0 && !result.first_of_string && !result.last_of_string))
    else $error("payload fields set on a non-payload result");

  // error code only on error results
  a_error_code: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind != lpc_pkg::KIND_ERROR) |-> (result.error_code == 3'd0))
    else $error("error code set on a non-error result");
`endif

endmodule
`default_nettype wire

// ===== bench/command_parse_monitor.sv =====
// monitor and predictor for the length-prefixed command parser
module command_parse_monitor
  import lpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_item_t  in_item,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t result,
  output int        mismatches,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS);

  // parser state as seen from outside
  mode_t       pmode;
  logic        in_opts;
  logic        opts_seen;
  logic        str_started;
  logic        sticky;
  logic        val_next;
  logic [2:0]  err_held;
  logic [63:0] remaining;
  logic [7:0]  str_count;

  out_item_t   predicted_events [$];
  out_item_t   oldest;

  task automatic report_mismatch(string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, int seen, int due);
    if (seen != due) report_mismatch($sformatf("%s is %0d, predicted %0d", name, seen, due));
  endtask

  function automatic logic [1:0] current_role();
    return in_opts ? (val_next ? ROLE_VALUE : ROLE_KEY) : ROLE_WORD;
  endfunction

  function automatic void finish_string();
    if (str_count != 8'd255) str_count++;
    str_started = 1'b0;
    if (in_opts) val_next = ~val_next;
    remaining = '0;
    pmode = MODE_LEN_START;
  endfunction

  function automatic void open_list(logic opts);
    in_opts = opts;
    str_count = '0;
    str_started = 1'b0;
    val_next = 1'b0;
    remaining = '0;
    pmode = MODE_LEN_START;
  endfunction

  function automatic out_item_t raise_error(logic [2:0] code);
    out_item_t r = '0;
    sticky = 1'b1;
    err_held = code;
    pmode = MODE_ERROR;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic out_item_t empty_string();
    out_item_t r = '0;
    r.kind = KIND_EMPTY;
    r.role = current_role();
    r.word_index = str_count;
    finish_string();
    return r;
  endfunction

  function automatic out_item_t parse_byte(in_item_t it);
    out_item_t   r;
    logic [7:0]  b;
    logic        is_digit;
    logic        is_blank;
    logic [63:0] d;
    r = '0;
    r.kind = KIND_FRAMING;
    b = it.in_byte;
    is_digit = b >= CHR_ZERO && b <= CHR_NINE;
    is_blank = b == CHR_SPACE || b == CHR_CR || b == CHR_LF || b == CHR_TAB;
    d = {56'd0, b - CHR_ZERO};
    if (sticky) begin
      r.kind = KIND_ERROR;
      r.error_code = err_held;
      return r;
    end
    case (pmode)
      MODE_BETWEEN: begin
        if (it.at_end) begin
          if (opts_seen) r = raise_error(ERR_EARLY_END);
          else r.kind = KIND_IN_END;
        end else if (is_blank) begin
          r.kind = KIND_FRAMING;
        end else if (b == CHR_L || (b == CHR_O && !opts_seen)) begin
          open_list(b == CHR_O);
        end else begin
          r = raise_error(ERR_BAD_TOKEN);
        end
      end
      MODE_LEN_START: begin
        if (it.at_end) begin
          r = raise_error(ERR_EARLY_END);
        end else if (b == CHR_E) begin
          if (in_opts) begin
            r.kind = KIND_OPT_END;
            r.unpaired_key = val_next;
            opts_seen = 1'b1;
            in_opts = 1'b0;
            val_next = 1'b0;
            pmode = MODE_BETWEEN;
          end else if (str_count == 8'd0) begin
            r = raise_error(ERR_EMPTY_CMD);
          end else begin
            r.kind = KIND_CMD_END;
            opts_seen = 1'b0;
            pmode = MODE_BETWEEN;
          end
        end else if (b == CHR_COLON) begin
          r = empty_string();
        end else if (is_digit) begin
          remaining = d;
          pmode = MODE_LEN_DIGITS;
        end else begin
          r = raise_error(ERR_NO_COLON);
        end
      end
      MODE_LEN_DIGITS: begin
        if (it.at_end) begin
          r = raise_error(ERR_EARLY_END);
        end else if (is_digit) begin
          // the length must still fit after one more decimal place
          if (remaining > (LEN_MAX - d) / RADIX) r = raise_error(ERR_OVERFLOW);
          else remaining = remaining * RADIX + d;
        end else if (b == CHR_COLON) begin
          if (remaining == '0) begin
            r = empty_string();
          end else begin
            str_started = 1'b0;
            pmode = MODE_PAYLOAD;
          end
        end else begin
          r = raise_error(ERR_NO_COLON);
        end
      end
      MODE_PAYLOAD: begin
        if (it.at_end) begin
          r = raise_error(ERR_EARLY_END);
        end else begin
          r.kind = KIND_PAYLOAD;
          r.data_byte = b;
          r.role = current_role();
          r.word_index = str_count;
          r.first_of_string = !str_started;
          str_started = 1'b1;
          if (remaining != '0) remaining--;
          r.last_of_string = remaining == '0;
          if (remaining == '0) finish_string();
        end
      end
      default: r = raise_error(err_held);
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pmode = MODE_BETWEEN;
      in_opts = 1'b0;
      opts_seen = 1'b0;
      str_started = 1'b0;
      sticky = 1'b0;
      val_next = 1'b0;
      err_held = '0;
      remaining = '0;
      str_count = '0;
      predicted_events.delete();
      mismatches = 0;
    end else begin
      // a byte pushed at this edge cannot have its result popped at the same edge, so the pop side goes first
      if (pop && !empty) begin
        if (predicted_events.size() == 0) begin
          report_mismatch($sformatf("result kind %0d with nothing predicted", result.kind));
        end else begin
          oldest = predicted_events.pop_front();
          compare_field("kind", result.kind, oldest.kind);
          compare_field("data_byte", result.data_byte, oldest.data_byte);
          compare_field("role", result.role, oldest.role);
          compare_field("first_of_string", result.first_of_string, oldest.first_of_string);
          compare_field("last_of_string", result.last_of_string, oldest.last_of_string);
          compare_field("word_index", result.word_index, oldest.word_index);
          compare_field("unpaired_key", result.unpaired_key, oldest.unpaired_key);
          compare_field("error_code", result.error_code, oldest.error_code);
        end
      end
      if (push && !full) begin
        predicted_events.insert(predicted_events.size(), parse_byte(in_item));
      end
    end
    pending = predicted_events.size();
  end

endmodule

// ===== bench/testbench.sv =====
// stimulus and verdict for the length-prefixed command parser
module testbench;
  import lpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 400;

  logic      clk = 1'b0;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result;
  int        mismatches;
  int        pending;

  in_item_t  byte_stream [$];
  int        stall_odds = 0;
  int        pop_gap = 0;
  int        quiet_cycles = 0;

  always #1 clk = ~clk;

  length_prefixed_command_parser_core u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  command_parse_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .mismatches (mismatches),
    .pending    (pending)
  );

  function automatic void put(logic [7:0] b);
    in_item_t it;
    it.in_byte = b;
    it.at_end  = 1'b0;
    byte_stream.insert(byte_stream.size(), it);
  endfunction

  // end mark carries a random byte that the parser must ignore
  function automatic void put_end();
    in_item_t it;
    it.in_byte = 8'($urandom_range(0, 255));
    it.at_end  = 1'b1;
    byte_stream.insert(byte_stream.size(), it);
  endfunction

  function automatic void put_digits(longint unsigned v);
    string s;
    s = $sformatf("%0d", v);
    foreach (s[k]) put(s[k]);
  endfunction

  function automatic logic [7:0] marker_byte();
    case ($urandom_range(0, 5))
      0: return CHR_E;
      1: return CHR_COLON;
      2: return CHR_O;
      3: return CHR_L;
      4: return CHR_SPACE;
      default: return CHR_ZERO + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic void put_blanks();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: put(CHR_SPACE);
        1: put(CHR_CR);
        2: put(CHR_LF);
        default: put(CHR_TAB);
      endcase
    end
  endfunction

  function automatic void add_string(int len);
    if (len == 0 && $urandom_range(0, 1) == 1) begin
      put(CHR_COLON);
    end else begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) put(CHR_ZERO);
      put_digits(len);
      put(CHR_COLON);
      repeat (len) put($urandom_range(0, 3) == 0 ? marker_byte() : 8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void add_list(logic opts, int n);
    put(opts ? CHR_O : CHR_L);
    repeat (n) add_string($urandom_range(0, 9) == 0 ? $urandom_range(7, 40) : $urandom_range(0, 6));
    put(CHR_E);
  endfunction

  // parser can sit stalled for a burst on each side, nothing more
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      pop_gap = $urandom_range(1, 13) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    int         group;
    int         long_at;
    logic [7:0] b;
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;

    // directed opening: blanks, an unpaired key, 'e' as payload, padded empty word
    put_end();
    put(CHR_SPACE);
    put(CHR_CR);
    put(CHR_LF);
    put(CHR_TAB);
    put(CHR_O);
    put(CHR_ZERO + 8'd1);
    put(CHR_COLON);
    put(8'h00);
    put(CHR_COLON);
    put(CHR_ZERO);
    put(CHR_COLON);
    put(CHR_E);
    put(CHR_L);
    put(CHR_ZERO + 8'd2);
    put(CHR_COLON);
    put(8'hff);
    put(CHR_E);
    put(CHR_ZERO);
    put(CHR_ZERO);
    put(CHR_COLON);
    put(CHR_E);
    put_end();

    // well-formed items, one of them a command list long enough to saturate the index
    group = 0;
    long_at = $urandom_range(5, 30);
    while (byte_stream.size() < 1300) begin
      if (group == long_at) begin
        put(CHR_L);
        for (int i = 0; i < 300; i++) begin
          if (i > 250 && $urandom_range(0, 2) == 0) add_string($urandom_range(1, 3));
          else put(CHR_COLON);
        end
        put(CHR_E);
      end else begin
        put_blanks();
        if ($urandom_range(0, 1) == 1) begin
          add_list(1'b1, $urandom_range(0, 5));
          put_blanks();
        end
        add_list(1'b0, $urandom_range(1, 5));
        if ($urandom_range(0, 7) == 0) put_end();
      end
      group++;
    end

    // errors are sticky, so only one kind of failure can close the run
    case ($urandom_range(0, 7))
      0: begin
        do b = 8'($urandom_range(0, 255));
        while (b == CHR_SPACE || b == CHR_CR || b == CHR_LF || b == CHR_TAB ||
               b == CHR_O || b == CHR_L);
        put(b);
      end
      1: begin
        add_list(1'b1, $urandom_range(0, 2));
        put(CHR_O);
      end
      2: begin
        put(CHR_L);
        if ($urandom_range(0, 1) == 1) put_digits($urandom_range(0, 99));
        do b = 8'($urandom_range(0, 255));
        while ((b >= CHR_ZERO && b <= CHR_NINE) || b == CHR_COLON || b == CHR_E);
        put(b);
      end
      3: begin
        put(CHR_L);
        if ($urandom_range(0, 1) == 1) begin
          // largest length that still fits, cut short by the end mark
          put_digits((64'd1 << LENGTH_BITS) - 64'd1);
          put(CHR_COLON);
          repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 1) == 1) begin
          put_digits($urandom_range(1, 9));
        end
        put_end();
      end
      4: begin
        add_list(1'b1, $urandom_range(0, 3));
        put_end();
      end
      5: begin
        put(CHR_L);
        put(CHR_E);
      end
      6: begin
        put(CHR_L);
        if ($urandom_range(0, 1) == 1) put_digits(64'd1 << LENGTH_BITS);
        else repeat ($urandom_range(11, 20)) put(CHR_ZERO + 8'($urandom_range(1, 9)));
      end
      default: ;
    endcase
    repeat (30) begin
      if ($urandom_range(0, 5) == 0) put_end();
      else put($urandom_range(0, 1) == 1 ? marker_byte() : 8'($urandom_range(0, 255)));
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (byte_stream[i]) begin
      if (i >= byte_stream.size() * 85 / 100) begin
        stall_odds = 0;
      end else if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_odds = 0;
          1: stall_odds = 3;
          default: stall_odds = 10;
        endcase
      end
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      push <= 1'b1;
      in_item <= byte_stream[i];
      @(posedge clk);
      while (full) @(posedge clk);
      @(negedge clk);
    end
    push <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lpc_pkg.sv
design/lpc_front.sv
design/lpc_back.sv
design/length_prefixed_command_parser_core.sv
bench/command_parse_monitor.sv
bench/testbench.sv
